>>> rtl/core/rsfc_pkg.sv
// ----------------------------------------------------------------------------
// rsfc_pkg: shared types and constants of the radio status frame checker
// Opcodes, event codes, the command carried from front to back, frame
// constants and the fixed battery and fault encodings.
// ----------------------------------------------------------------------------
package rsfc_pkg;

	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_RESET = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		EV_ACCEPT = 3'd0,
		EV_ADDR   = 3'd1,
		EV_REJECT = 3'd2,
		EV_OTHER  = 3'd3,
		EV_TICK   = 3'd4,
		EV_RESET  = 3'd5
	} event_t;

	// Command handed from the classifier to the link-state engine
	typedef struct packed {
		event_t     kind;
		logic [2:0] battery_bits;
		logic [7:0] status_byte;
	} cmd_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic head_valid;
		logic full;
	} q_status_t;

	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [7:0] HDR_STATUS  = 8'hAA;
	localparam logic [7:0] HDR_ADDRESS = 8'hCC;
	localparam logic [7:0] BATT_MASK   = 8'h07;

	// Frame positions (byte index of the final byte = length - 1)
	localparam logic [3:0] IDX_HEADER   = 4'd0;
	localparam logic [3:0] IDX_BATTERY  = 4'd1;
	localparam logic [3:0] IDX_STATUS   = 4'd2;
	localparam logic [3:0] IDX_ADDR_LO  = 4'd1;
	localparam logic [3:0] IDX_ADDR_HI  = 4'd5;
	localparam logic [3:0] IDX_LAST_STS = 4'd4;
	localparam logic [3:0] IDX_LAST_ADR = 4'd6;
	localparam logic [3:0] COUNT_MAX    = 4'd15;

	// Battery codes and levels
	localparam logic [2:0] BC_EMPTY = 3'd4;
	localparam logic [2:0] BC_LOW   = 3'd0;
	localparam logic [2:0] BC_MID   = 3'd1;
	localparam logic [2:0] BC_HIGH  = 3'd2;
	localparam logic [2:0] BC_FULL  = 3'd3;
	localparam logic [6:0] BATT_0   = 7'd0;
	localparam logic [6:0] BATT_10  = 7'd10;
	localparam logic [6:0] BATT_40  = 7'd40;
	localparam logic [6:0] BATT_70  = 7'd70;
	localparam logic [6:0] BATT_100 = 7'd100;

	// Status byte values and fault codes
	localparam logic [7:0] SB_NONE     = 8'h00;
	localparam logic [7:0] SB_OVERTEMP = 8'h40;
	localparam logic [7:0] SB_F1       = 8'h01;
	localparam logic [7:0] SB_F2       = 8'h10;
	localparam logic [7:0] SB_F3       = 8'h20;
	localparam logic [7:0] SB_F5       = 8'h08;
	localparam logic [7:0] SB_F6       = 8'h80;
	localparam logic [2:0] FC_NONE     = 3'd0;
	localparam logic [2:0] FC_1        = 3'd1;
	localparam logic [2:0] FC_2        = 3'd2;
	localparam logic [2:0] FC_3        = 3'd3;
	localparam logic [2:0] FC_OVERTEMP = 3'd4;
	localparam logic [2:0] FC_5        = 3'd5;
	localparam logic [2:0] FC_6        = 3'd6;

	localparam logic [2:0] MS_PHASE_LAST = 3'd4;
	localparam logic [7:0] SILENCE_LIMIT = 8'd255;

endpackage

>>> rtl/core/rsfc_rx_if.sv
// ----------------------------------------------------------------------------
// rsfc_rx_if: input request channel
// Opcode, frame byte and last-byte mark with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsfc_rx_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output opcode, output data_byte, output last_byte,
		input ready);
	modport sink (input valid, input opcode, input data_byte, input last_byte,
		output ready);
endinterface

>>> rtl/core/rsfc_evt_if.sv
// ----------------------------------------------------------------------------
// rsfc_evt_if: event result channel
// Event kind and link status snapshot with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsfc_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [6:0] battery_percent;
	logic [2:0] error_code;
	logic [7:0] link_silence;
	logic       link_connected;

	modport source (output valid, output event_kind, output battery_percent,
		output error_code, output link_silence, output link_connected, input ready);
	modport sink (input valid, input event_kind, input battery_percent,
		input error_code, input link_silence, input link_connected, output ready);
endinterface

>>> rtl/core/rsfc_cfg_if.sv
// ----------------------------------------------------------------------------
// rsfc_cfg_if: configuration write channel
// Device address write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [39:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/radio_status_frame_checker_top.sv
// ----------------------------------------------------------------------------
// radio_status_frame_checker_top: radio status frame checker
// Path: a final byte, tick or session reset accepted on rx is queued, then
//   registered into the link engine's output stage once evt is free.
//   Non-final bytes give no event.
// Throughput: one request per cycle while the queue has room, set by the
//   two-entry command queue and the link engine's single registered stage.
// Reset: arst_n clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module radio_status_frame_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	rsfc_rx_if.sink     rx,
	rsfc_cfg_if.sink    cfg,
	rsfc_evt_if.source  evt
);

	// Front side: absorb frame bytes into the running sum, header, battery
	// bits, status byte and address-match flag; at the last byte judge the
	// frame by length, header and sum and queue a command. Ticks and session
	// resets go straight into the queue so ordering is kept.
	rsfc_pkg::cmd_t      push_cmd;
	rsfc_pkg::cmd_t      head_cmd;
	rsfc_pkg::q_status_t q_status;
	logic                push;
	logic                pop;

	rsfc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.cfg      (cfg),
		.q_status (q_status),
		.push     (push),
		.push_cmd (push_cmd)
	);

	// Queue decouples the intake from the output stall: the front keeps
	// taking requests while a finished event waits on evt, until the queue is full.
	rsfc_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.q_status (q_status)
	);

	// Back side: battery level, sticky fault code, silence count with its
	// five-tick divider and the connected flag; every command yields one
	// registered event carrying the state after it.
	rsfc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_cmd (head_cmd),
		.q_status (q_status),
		.pop      (pop),
		.evt      (evt)
	);

endmodule

>>> rtl/core/rsfc_front.sv
// ----------------------------------------------------------------------------
// rsfc_front: request intake and frame classifier
// Absorb frame bytes, judge frames at the last byte and queue commands.
// ----------------------------------------------------------------------------
module rsfc_front (
	input  logic                  clk,
	input  logic                  arst_n,
	rsfc_rx_if.sink               rx,
	rsfc_cfg_if.sink              cfg,
	input  rsfc_pkg::q_status_t   q_status,
	output logic                  push,
	output rsfc_pkg::cmd_t        push_cmd
);

	logic [39:0] device_address_q;
	logic [3:0]  byte_count_q;
	logic [7:0]  running_sum_q;
	logic [7:0]  header_byte_q;
	logic [2:0]  battery_bits_q;
	logic [7:0]  status_byte_q;
	logic        address_match_q;

	logic        accept;
	logic        is_byte;
	logic        addr_range;
	logic [7:0]  want_byte;
	logic        sum_ok;

	assign rx.ready  = !q_status.full;
	assign cfg.ready = 1'b1;
	assign accept    = rx.valid && rx.ready;
	assign is_byte   = rx.opcode == rsfc_pkg::OP_BYTE;

	assign push = accept && ((is_byte && rx.last_byte) || rx.opcode == rsfc_pkg::OP_TICK
		|| rx.opcode == rsfc_pkg::OP_RESET);

	assign addr_range = byte_count_q >= rsfc_pkg::IDX_ADDR_LO
		&& byte_count_q <= rsfc_pkg::IDX_ADDR_HI;

	// Address byte expected at the current frame position
	always_comb begin
		case (byte_count_q)
			4'd1: want_byte = device_address_q[39:32];
			4'd2: want_byte = device_address_q[31:24];
			4'd3: want_byte = device_address_q[23:16];
			4'd4: want_byte = device_address_q[15:8];
			4'd5: want_byte = device_address_q[7:0];
			default: want_byte = 8'h00;
		endcase
	end

	assign sum_ok = rx.data_byte == running_sum_q;

	always_comb begin
		push_cmd.battery_bits = battery_bits_q;
		push_cmd.status_byte  = status_byte_q;
		case (rx.opcode)
			rsfc_pkg::OP_TICK:  push_cmd.kind = rsfc_pkg::EV_TICK;
			rsfc_pkg::OP_RESET: push_cmd.kind = rsfc_pkg::EV_RESET;
			default: begin
				if (byte_count_q == rsfc_pkg::IDX_LAST_STS) begin
					push_cmd.kind = (header_byte_q == rsfc_pkg::HDR_STATUS && sum_ok)
						? rsfc_pkg::EV_ACCEPT : rsfc_pkg::EV_REJECT;
				end else if (byte_count_q == rsfc_pkg::IDX_LAST_ADR) begin
					push_cmd.kind = (header_byte_q == rsfc_pkg::HDR_ADDRESS
						&& address_match_q && sum_ok)
						? rsfc_pkg::EV_ADDR : rsfc_pkg::EV_REJECT;
				end else begin
					push_cmd.kind = rsfc_pkg::EV_OTHER;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			device_address_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			running_sum_q   <= '0;
			header_byte_q   <= '0;
			battery_bits_q  <= '0;
			status_byte_q   <= '0;
			address_match_q <= 1'b1;
		end else if (accept) begin
			if ((is_byte && rx.last_byte) || rx.opcode == rsfc_pkg::OP_RESET) begin
				// drop the frame accumulators
				byte_count_q    <= '0;
				running_sum_q   <= '0;
				header_byte_q   <= '0;
				battery_bits_q  <= '0;
				status_byte_q   <= '0;
				address_match_q <= 1'b1;
			end else if (is_byte) begin
				if (byte_count_q == rsfc_pkg::IDX_HEADER) begin
					header_byte_q <= rx.data_byte;
				end
				if (byte_count_q == rsfc_pkg::IDX_BATTERY) begin
					battery_bits_q <= 3'(rx.data_byte & rsfc_pkg::BATT_MASK);
				end
				if (byte_count_q == rsfc_pkg::IDX_STATUS) begin
					status_byte_q <= rx.data_byte;
				end
				if (addr_range && rx.data_byte != want_byte) begin
					address_match_q <= 1'b0;
				end
				running_sum_q <= running_sum_q + rx.data_byte;
				if (byte_count_q != rsfc_pkg::COUNT_MAX) begin
					byte_count_q <= byte_count_q + 4'd1;
				end
			end
		end
	end

endmodule

>>> rtl/core/rsfc_cmd_queue.sv
// ----------------------------------------------------------------------------
// rsfc_cmd_queue: command queue between classifier and link engine
// Small register FIFO; head is read at the read pointer.
// ----------------------------------------------------------------------------
module rsfc_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rsfc_pkg::cmd_t      push_cmd,
	input  logic                pop,
	output rsfc_pkg::cmd_t      head_cmd,
	output rsfc_pkg::q_status_t q_status
);

	localparam int unsigned PTR_W = $clog2(rsfc_pkg::QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(rsfc_pkg::QUEUE_DEPTH + 1);

	rsfc_pkg::cmd_t    slot_q [rsfc_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head_cmd            = slot_q[rd_ptr_q];
	assign q_status.head_valid = count_q != '0;
	assign q_status.full       = count_q == CNT_W'(rsfc_pkg::QUEUE_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(rsfc_pkg::QUEUE_DEPTH - 1))
					? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(rsfc_pkg::QUEUE_DEPTH - 1))
					? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/core/rsfc_back.sv
// ----------------------------------------------------------------------------
// rsfc_back: link-state engine
// Apply queued commands to the link state and register the event output.
// ----------------------------------------------------------------------------
module rsfc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rsfc_pkg::cmd_t      head_cmd,
	input  rsfc_pkg::q_status_t q_status,
	output logic                pop,
	rsfc_evt_if.source          evt
);

	logic [6:0] battery_level_q;
	logic [2:0] fault_code_q;
	logic [7:0] silence_count_q;
	logic       connected_q;
	logic [2:0] ms_phase_q;
	logic       evt_valid_q;
	logic [2:0] evt_kind_q;

	logic [6:0] battery_d;
	logic [2:0] fault_d;
	logic [7:0] silence_d;
	logic       connected_d;
	logic [2:0] phase_d;
	logic [6:0] battery_map;
	logic [2:0] fault_map;

	assign pop = q_status.head_valid && (!evt_valid_q || evt.ready);

	always_comb begin
		case (head_cmd.battery_bits)
			rsfc_pkg::BC_EMPTY: battery_map = rsfc_pkg::BATT_0;
			rsfc_pkg::BC_LOW:   battery_map = rsfc_pkg::BATT_10;
			rsfc_pkg::BC_MID:   battery_map = rsfc_pkg::BATT_40;
			rsfc_pkg::BC_HIGH:  battery_map = rsfc_pkg::BATT_70;
			rsfc_pkg::BC_FULL:  battery_map = rsfc_pkg::BATT_100;
			default:            battery_map = battery_level_q;
		endcase
	end

	// Overtemperature always wins; other faults only land on a clean code
	always_comb begin
		fault_map = fault_code_q;
		if (head_cmd.status_byte == rsfc_pkg::SB_OVERTEMP) begin
			fault_map = rsfc_pkg::FC_OVERTEMP;
		end else if (head_cmd.status_byte != rsfc_pkg::SB_NONE
			&& fault_code_q == rsfc_pkg::FC_NONE) begin
			case (head_cmd.status_byte)
				rsfc_pkg::SB_F1: fault_map = rsfc_pkg::FC_1;
				rsfc_pkg::SB_F2: fault_map = rsfc_pkg::FC_2;
				rsfc_pkg::SB_F3: fault_map = rsfc_pkg::FC_3;
				rsfc_pkg::SB_F5: fault_map = rsfc_pkg::FC_5;
				rsfc_pkg::SB_F6: fault_map = rsfc_pkg::FC_6;
				default:         fault_map = fault_code_q;
			endcase
		end
	end

	always_comb begin
		battery_d   = battery_level_q;
		fault_d     = fault_code_q;
		silence_d   = silence_count_q;
		connected_d = connected_q;
		phase_d     = ms_phase_q;
		case (head_cmd.kind)
			rsfc_pkg::EV_ACCEPT: begin
				battery_d   = battery_map;
				fault_d     = fault_map;
				silence_d   = '0;
				connected_d = 1'b1;
			end
			rsfc_pkg::EV_TICK: begin
				if (ms_phase_q == rsfc_pkg::MS_PHASE_LAST) begin
					phase_d = '0;
					if (silence_count_q < rsfc_pkg::SILENCE_LIMIT) begin
						silence_d = silence_count_q + 8'd1;
					end
				end else begin
					phase_d = ms_phase_q + 3'd1;
				end
			end
			rsfc_pkg::EV_RESET: begin
				battery_d   = '0;
				fault_d     = '0;
				silence_d   = '0;
				connected_d = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			battery_level_q <= '0;
			fault_code_q    <= '0;
			silence_count_q <= '0;
			connected_q     <= 1'b0;
			ms_phase_q      <= '0;
			evt_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				battery_level_q <= battery_d;
				fault_code_q    <= fault_d;
				silence_count_q <= silence_d;
				connected_q     <= connected_d;
				ms_phase_q      <= phase_d;
				evt_valid_q     <= 1'b1;
			end else if (evt.ready) begin
				evt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			evt_kind_q <= head_cmd.kind;
		end
	end

	assign evt.valid           = evt_valid_q;
	assign evt.event_kind      = evt_kind_q;
	assign evt.battery_percent = battery_level_q;
	assign evt.error_code      = fault_code_q;
	assign evt.link_silence    = silence_count_q;
	assign evt.link_connected  = connected_q;

endmodule

>>> rtl/core/rsfc_checker.sv
// ----------------------------------------------------------------------------
// rsfc_checker: port-level checks of the radio status frame checker
// Output handshake and consistency of the reported link state.
// ----------------------------------------------------------------------------
module rsfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       evt_valid,
	input logic       evt_ready,
	input logic [2:0] event_kind,
	input logic [6:0] battery_percent,
	input logic [2:0] error_code,
	input logic [7:0] link_silence,
	input logic       link_connected
);

	// Hold a stalled event and its payload
	a_evt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && !evt_ready |=> evt_valid && $stable(event_kind)
			&& $stable(battery_percent) && $stable(error_code)
			&& $stable(link_silence) && $stable(link_connected))
		else $error("stalled event changed");

	// Accepted status frame connects and clears silence
	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && event_kind == rsfc_pkg::EV_ACCEPT |->
			link_connected && link_silence == 8'd0)
		else $error("accepted status without link update");

	// Session reset clears the link state
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && event_kind == rsfc_pkg::EV_RESET |->
			!link_connected && link_silence == 8'd0
			&& error_code == rsfc_pkg::FC_NONE && battery_percent == rsfc_pkg::BATT_0)
		else $error("session reset left link state");

	// Battery level is always one of the decoded levels
	a_battery_level: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid |-> battery_percent == rsfc_pkg::BATT_0
			|| battery_percent == rsfc_pkg::BATT_10 || battery_percent == rsfc_pkg::BATT_40
			|| battery_percent == rsfc_pkg::BATT_70 || battery_percent == rsfc_pkg::BATT_100)
		else $error("battery level off the decode table");

endmodule

bind radio_status_frame_checker_top rsfc_checker u_rsfc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.evt_valid       (evt.valid),
	.evt_ready       (evt.ready),
	.event_kind      (evt.event_kind),
	.battery_percent (evt.battery_percent),
	.error_code      (evt.error_code),
	.link_silence    (evt.link_silence),
	.link_connected  (evt.link_connected)
);

>>> bench/tb_radio_status_frame_checker_top.sv
// ----------------------------------------------------------------------------
// tb_radio_status_frame_checker_top: self-checking bench of the frame checker
// Queue frame bytes, ticks and session resets as requests, predict each link
// event inside the bench and compare every event field against it. Walk the
// device address through several values, extremes included, between phases.
// ----------------------------------------------------------------------------
module tb_radio_status_frame_checker_top;

	localparam logic [1:0] OP_UNUSED      = 2'd3;
	localparam int         SETTLE_CYCLES  = 8;
	localparam int         WATCHDOG_LIMIT = 1000;

	// One request on the receive channel
	typedef struct packed {
		logic [1:0] op;
		logic [7:0] data;
		logic       last;
	} rx_req_t;

	// One event as the block should report it
	typedef struct packed {
		rsfc_pkg::event_t kind;
		logic [6:0]       percent;
		logic [2:0]       fault;
		logic [7:0]       silence;
		logic             connected;
	} link_event_t;

	// Ways to spoil a generated frame
	typedef enum {FLAW_NONE, FLAW_HEADER, FLAW_SUM, FLAW_LENGTH, FLAW_ADDRESS} flaw_t;

	typedef logic [7:0] frame_q_t[$];

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsfc_rx_if  rx_bus ();
	rsfc_cfg_if cfg_bus ();
	rsfc_evt_if evt_bus ();

	radio_status_frame_checker_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_bus),
		.cfg    (cfg_bus),
		.evt    (evt_bus)
	);

	// Stimulus side: requests waiting for the driver and their counts
	rx_req_t     rx_backlog[$];
	rx_req_t     next_req;
	int          rx_pushed = 0;
	int          rx_taken = 0;
	int          useful_reqs = 0;
	bit          steady = 1'b0;

	// Checking side: events predicted but not yet seen
	link_event_t events_due[$];
	link_event_t due;
	int          mismatches = 0;
	int          idle_cycles = 0;

	// Bench copy of the block state
	logic [39:0] dev_address;
	logic [3:0]  frm_count;
	logic [7:0]  frm_sum;
	logic [7:0]  frm_header;
	logic [2:0]  frm_batt;
	logic [7:0]  frm_status;
	logic        frm_addr_ok;
	logic [6:0]  lvl;
	logic [2:0]  fault;
	logic [7:0]  silence;
	logic        linked;
	logic [2:0]  tick_phase;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Drop the frame accumulators back to their idle values
	function automatic void clear_frame_state();
		frm_count = '0;
		frm_sum = '0;
		frm_header = '0;
		frm_batt = '0;
		frm_status = '0;
		frm_addr_ok = 1'b1;
	endfunction

	// Advance the bench state by one request and queue the event it causes
	function automatic void predict_link_event(logic [1:0] op, logic [7:0] b, logic last);
		rsfc_pkg::event_t kind;
		logic             emit;
		logic [7:0]       masked;
		logic [39:0]      shifted;
		int unsigned      shift;
		emit = 1'b1;
		kind = rsfc_pkg::EV_TICK;
		case (op)
			rsfc_pkg::OP_BYTE: begin
				if (!last) begin
					// Absorb a body byte; only positions 0 to 5 are kept
					if (frm_count == rsfc_pkg::IDX_HEADER) frm_header = b;
					if (frm_count == rsfc_pkg::IDX_BATTERY) begin
						masked = b & rsfc_pkg::BATT_MASK;
						frm_batt = masked[2:0];
					end
					if (frm_count == rsfc_pkg::IDX_STATUS) frm_status = b;
					if (frm_count >= rsfc_pkg::IDX_ADDR_LO
						&& frm_count <= rsfc_pkg::IDX_ADDR_HI) begin
						shift = (rsfc_pkg::IDX_ADDR_HI - frm_count) * 8;
						shifted = dev_address >> shift;
						if (b != shifted[7:0]) frm_addr_ok = 1'b0;
					end
					frm_sum = frm_sum + b;
					if (frm_count != rsfc_pkg::COUNT_MAX) frm_count = frm_count + 1'b1;
					emit = 1'b0;
				end else begin
					// Judge the frame by its length, then start over
					if (frm_count == rsfc_pkg::IDX_LAST_STS) begin
						if (frm_header == rsfc_pkg::HDR_STATUS && b == frm_sum) begin
							kind = rsfc_pkg::EV_ACCEPT;
							silence = '0;
							linked = 1'b1;
							case (frm_batt)
								rsfc_pkg::BC_EMPTY: lvl = rsfc_pkg::BATT_0;
								rsfc_pkg::BC_LOW:   lvl = rsfc_pkg::BATT_10;
								rsfc_pkg::BC_MID:   lvl = rsfc_pkg::BATT_40;
								rsfc_pkg::BC_HIGH:  lvl = rsfc_pkg::BATT_70;
								rsfc_pkg::BC_FULL:  lvl = rsfc_pkg::BATT_100;
								default:  ;
							endcase
							// Overtemperature always wins; others only land on a clean code
							if (frm_status == rsfc_pkg::SB_OVERTEMP) begin
								fault = rsfc_pkg::FC_OVERTEMP;
							end else if (frm_status != rsfc_pkg::SB_NONE
								&& fault == rsfc_pkg::FC_NONE) begin
								case (frm_status)
									rsfc_pkg::SB_F1: fault = rsfc_pkg::FC_1;
									rsfc_pkg::SB_F2: fault = rsfc_pkg::FC_2;
									rsfc_pkg::SB_F3: fault = rsfc_pkg::FC_3;
									rsfc_pkg::SB_F5: fault = rsfc_pkg::FC_5;
									rsfc_pkg::SB_F6: fault = rsfc_pkg::FC_6;
									default: ;
								endcase
							end
						end else begin
							kind = rsfc_pkg::EV_REJECT;
						end
					end else if (frm_count == rsfc_pkg::IDX_LAST_ADR) begin
						if (frm_header == rsfc_pkg::HDR_ADDRESS && frm_addr_ok
							&& b == frm_sum)
							kind = rsfc_pkg::EV_ADDR;
						else
							kind = rsfc_pkg::EV_REJECT;
					end else begin
						kind = rsfc_pkg::EV_OTHER;
					end
					clear_frame_state();
				end
			end
			rsfc_pkg::OP_TICK: begin
				kind = rsfc_pkg::EV_TICK;
				if (tick_phase == rsfc_pkg::MS_PHASE_LAST) begin
					tick_phase = '0;
					if (silence != rsfc_pkg::SILENCE_LIMIT) silence = silence + 1'b1;
				end else begin
					tick_phase = tick_phase + 1'b1;
				end
			end
			rsfc_pkg::OP_RESET: begin
				kind = rsfc_pkg::EV_RESET;
				clear_frame_state();
				fault = rsfc_pkg::FC_NONE;
				silence = '0;
				linked = 1'b0;
				lvl = rsfc_pkg::BATT_0;
			end
			default: emit = 1'b0;
		endcase
		if (emit) events_due.push_back('{kind, lvl, fault, silence, linked});
	endfunction

	// ------------------------------------------------------------------------
	// Reporting
	// ------------------------------------------------------------------------

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [7:0] got,
		input logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	task automatic push_req(input logic [1:0] op, input logic [7:0] data, input logic last);
		rx_backlog.push_back('{op, data, last});
		rx_pushed++;
		if (op != OP_UNUSED) useful_reqs++;
	endtask

	// Seal a frame body with its checksum, apply a flaw, and queue the bytes.
	// Mingle scatters ticks between bytes, which must not disturb the frame.
	task automatic queue_frame(input frame_q_t body, input flaw_t flaw, input bit mingle);
		logic [7:0] sum;
		logic [7:0] spoil;
		spoil = $urandom_range(1, 255);
		if (flaw == FLAW_HEADER && body.size() != 0) body[0] = body[0] ^ spoil;
		if (flaw == FLAW_LENGTH) begin
			if ($urandom_range(1) == 0 && body.size() != 0)
				void'(body.pop_back());
			else
				body.push_back($urandom);
		end
		sum = '0;
		for (int i = 0; i < body.size(); i++) sum = sum + body[i];
		body.push_back(flaw == FLAW_SUM ? sum ^ spoil : sum);
		for (int i = 0; i < body.size(); i++) begin
			if (mingle && i != 0 && $urandom_range(99) < 6)
				push_req(rsfc_pkg::OP_TICK, $urandom, $urandom);
			push_req(rsfc_pkg::OP_BYTE, body[i], i == body.size() - 1);
		end
	endtask

	task automatic queue_status_frame(input logic [7:0] batt, input logic [7:0] status,
		input logic [7:0] spare, input flaw_t flaw, input bit mingle);
		frame_q_t body;
		body = '{rsfc_pkg::HDR_STATUS, batt, status, spare};
		queue_frame(body, flaw, mingle);
	endtask

	// Build an address frame from the current device address
	task automatic queue_address_frame(input flaw_t flaw, input bit mingle);
		frame_q_t    body;
		logic [39:0] addr;
		logic [7:0]  spoil;
		addr = dev_address;
		body.push_back(rsfc_pkg::HDR_ADDRESS);
		for (int i = 4; i >= 0; i--) body.push_back(addr[i * 8 +: 8]);
		if (flaw == FLAW_ADDRESS) begin
			spoil = $urandom_range(1, 255);
			body[$urandom_range(1, 5)] ^= spoil;
		end
		queue_frame(body, flaw, mingle);
	endtask

	// Pick one random piece of traffic: mostly well-formed frames with random
	// content, the rest ticks, resets, odd lengths, broken frames and noise.
	task automatic random_step();
		int         sel;
		int         n;
		flaw_t      flaw;
		logic [7:0] status;
		frame_q_t   body;
		sel = $urandom_range(99);
		flaw = ($urandom_range(99) < 85) ? FLAW_NONE : flaw_t'($urandom_range(1, 4));
		if (sel < 40) begin
			case ($urandom_range(7))
				0: status = rsfc_pkg::SB_NONE;
				1: status = rsfc_pkg::SB_OVERTEMP;
				2: status = rsfc_pkg::SB_F1;
				3: status = rsfc_pkg::SB_F2;
				4: status = rsfc_pkg::SB_F3;
				5: status = rsfc_pkg::SB_F5;
				6: status = rsfc_pkg::SB_F6;
				default: status = $urandom;
			endcase
			queue_status_frame($urandom, status, $urandom, flaw, $urandom_range(3) == 0);
		end else if (sel < 60) begin
			queue_address_frame(flaw, $urandom_range(3) == 0);
		end else if (sel < 70) begin
			// Any length up to past the byte counter's saturation point
			n = $urandom_range(1, 18);
			for (int i = 1; i < n; i++) begin
				if (i == 1) begin
					case ($urandom_range(2))
						0: body.push_back(rsfc_pkg::HDR_STATUS);
						1: body.push_back(rsfc_pkg::HDR_ADDRESS);
						default: body.push_back($urandom);
					endcase
				end else begin
					body.push_back($urandom);
				end
			end
			queue_frame(body, $urandom_range(1) ? FLAW_SUM : FLAW_NONE, $urandom_range(3) == 0);
		end else if (sel < 85) begin
			n = $urandom_range(1, 6);
			repeat (n) push_req(rsfc_pkg::OP_TICK, $urandom, $urandom);
		end else if (sel < 90) begin
			push_req(rsfc_pkg::OP_RESET, $urandom, $urandom);
		end else if (sel < 95) begin
			// Cut a frame short and abandon it with a session reset
			n = $urandom_range(1, 6);
			push_req(rsfc_pkg::OP_BYTE, rsfc_pkg::HDR_STATUS, 1'b0);
			repeat (n) push_req(rsfc_pkg::OP_BYTE, $urandom, 1'b0);
			push_req(rsfc_pkg::OP_RESET, $urandom, $urandom);
		end else begin
			push_req(OP_UNUSED, $urandom, $urandom);
		end
	endtask

	task automatic random_chunk(input int count);
		int start;
		start = useful_reqs;
		while (useful_reqs - start < count) random_step();
	endtask

	function automatic logic [39:0] random_address();
		logic [63:0] wide;
		wide = {$urandom, $urandom};
		return wide[39:0];
	endfunction

	// Hold until every request is taken and every event has come, then let
	// the pipeline settle
	task automatic wait_drained();
		while (rx_taken != rx_pushed || events_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the device address; call only while the block is idle
	task automatic write_address(input logic [39:0] value);
		@(posedge clk);
		cfg_bus.valid <= 1'b1;
		cfg_bus.data <= value;
		do @(posedge clk); while (!cfg_bus.ready);
		dev_address = value;
		cfg_bus.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Driver: present the next request whenever the channel is free
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_bus.valid <= 1'b0;
		end else begin
			// Predict on the request that was taken at this edge
			if (rx_bus.valid && rx_bus.ready) begin
				predict_link_event(rx_bus.opcode, rx_bus.data_byte, rx_bus.last_byte);
				rx_taken++;
			end
			// Load the next request, or idle now and then unless steady
			if (!rx_bus.valid || rx_bus.ready) begin
				if (rx_backlog.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
					next_req = rx_backlog.pop_front();
					rx_bus.valid <= 1'b1;
					rx_bus.opcode <= next_req.op;
					rx_bus.data_byte <= next_req.data;
					rx_bus.last_byte <= next_req.last;
				end else begin
					rx_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: compare each event against the oldest prediction, stall at random
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			evt_bus.ready <= 1'b0;
		end else begin
			if (evt_bus.valid && evt_bus.ready) begin
				if (events_due.size() == 0) begin
					report_mismatch($sformatf("event %0d with none due", evt_bus.event_kind));
				end else begin
					due = events_due.pop_front();
					check_field("event_kind", evt_bus.event_kind, due.kind);
					check_field("battery_percent", evt_bus.battery_percent, due.percent);
					check_field("error_code", evt_bus.error_code, due.fault);
					check_field("link_silence", evt_bus.link_silence, due.silence);
					check_field("link_connected", evt_bus.link_connected, due.connected);
				end
			end
			evt_bus.ready <= steady || $urandom_range(99) >= 14;
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run if no channel moves for too long
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_bus.valid && rx_bus.ready) || (evt_bus.valid && evt_bus.ready)
				|| (cfg_bus.valid && cfg_bus.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("radio_status_frame_checker_top test failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		// Drive every input to a known value before the first edge
		rx_bus.valid = 1'b0;
		rx_bus.opcode = rsfc_pkg::OP_BYTE;
		rx_bus.data_byte = '0;
		rx_bus.last_byte = 1'b0;
		cfg_bus.valid = 1'b0;
		cfg_bus.data = '0;
		evt_bus.ready = 1'b0;

		// Start the bench state from the block's reset state
		dev_address = '0;
		clear_frame_state();
		lvl = rsfc_pkg::BATT_0;
		fault = rsfc_pkg::FC_NONE;
		silence = '0;
		linked = 1'b0;
		tick_phase = '0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part, address at its all-ones extreme
		write_address(40'hFF_FFFF_FFFF);
		// Overtemperature at full battery, then a plain fault that must not
		// replace it while the empty-battery code lands
		queue_status_frame(8'h03, rsfc_pkg::SB_OVERTEMP, 8'h00, FLAW_NONE, 1'b0);
		queue_status_frame(8'hFC, rsfc_pkg::SB_F1, 8'hFF, FLAW_NONE, 1'b0);
		// Matching address frame
		queue_address_frame(FLAW_NONE, 1'b0);
		// One full tick period raises the silence count
		repeat (5) push_req(rsfc_pkg::OP_TICK, 8'h00, 1'b0);
		// Unused opcode is ignored
		push_req(OP_UNUSED, 8'hFF, 1'b1);
		// Single-byte frame has another length
		push_req(rsfc_pkg::OP_BYTE, 8'hFF, 1'b1);
		push_req(rsfc_pkg::OP_RESET, 8'h00, 1'b0);
		wait_drained();

		// Tick burst raises the silence count over many periods
		write_address(random_address());
		repeat (100) push_req(rsfc_pkg::OP_TICK, $urandom, $urandom);
		random_chunk(170);
		wait_drained();

		// Address at zero; run this phase without idling on either side
		write_address(40'h00_0000_0000);
		steady = 1'b1;
		random_chunk(170);
		wait_drained();
		steady = 1'b0;

		// Idle on both sides again, keep the address
		random_chunk(170);
		wait_drained();

		write_address(random_address());
		random_chunk(170);
		wait_drained();

		if (mismatches == 0)
			$display("radio_status_frame_checker_top test passed");
		else
			$display("radio_status_frame_checker_top test failed");
		$finish;
	end

endmodule
